@@ rtl/kda_pkg.sv @@
// Shared types and constants for the keypad debounce and auto-repeat block.
// No dependencies.
package kda_pkg;

  localparam int unsigned KeyW      = 8;
  localparam int unsigned PeriodW   = 8;
  localparam int unsigned SlowCntW  = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [SlowCntW-1:0] SlowRepeats = 3'd5;

  localparam logic [PeriodW-1:0] NormalPeriodRst = 8'd10;
  localparam logic [PeriodW-1:0] FastPeriodRst   = 8'd2;

  // Key codes
  localparam logic [KeyW-1:0] KeyNone    = 8'd0;
  localparam logic [KeyW-1:0] KeyRight   = 8'd1;
  localparam logic [KeyW-1:0] KeyLeft    = 8'd2;
  localparam logic [KeyW-1:0] KeyUp      = 8'd3;
  localparam logic [KeyW-1:0] KeyDown    = 8'd4;
  localparam logic [KeyW-1:0] KeyExec    = 8'd5;
  localparam logic [KeyW-1:0] KeyOutput  = 8'd6;
  localparam logic [KeyW-1:0] KeyPreset  = 8'd7;
  localparam logic [KeyW-1:0] KeyGenlock = 8'd8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHorizRepeat = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgVertRepeat  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNormalPer   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgFastPer     = 2'd3;

  typedef struct packed {
    logic               horiz_repeat;
    logic               vert_repeat;
    logic [PeriodW-1:0] normal_period;
    logic [PeriodW-1:0] fast_period;
  } cfg_t;

  typedef struct packed {
    logic            cmd_valid;
    logic [KeyW-1:0] cmd_key;
    logic            timer_clear;
  } res_t;

endpackage

@@ rtl/kda_cfg.sv @@
// Configuration register file of the keypad debounce block.
// Depends on kda_pkg.
module kda_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [kda_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [kda_pkg::CfgDataW-1:0] data_i,
  output kda_pkg::cfg_t                cfg_o
);

  kda_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.horiz_repeat  <= 1'b0;
      cfg_q.vert_repeat   <= 1'b0;
      cfg_q.normal_period <= kda_pkg::NormalPeriodRst;
      cfg_q.fast_period   <= kda_pkg::FastPeriodRst;
    end else if (we_i) begin
      unique case (idx_i)
        kda_pkg::CfgHorizRepeat: cfg_q.horiz_repeat  <= data_i[0];
        kda_pkg::CfgVertRepeat:  cfg_q.vert_repeat   <= data_i[0];
        kda_pkg::CfgNormalPer:   cfg_q.normal_period <= data_i[kda_pkg::PeriodW-1:0];
        kda_pkg::CfgFastPer:     cfg_q.fast_period   <= data_i[kda_pkg::PeriodW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/kda_core.sv @@
// Debounce and typematic state, updated by combinational logic and registered per scan.
// Depends on kda_pkg.
module kda_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kda_pkg::cfg_t            cfg_i,
  input  logic                     step_i,
  input  logic [kda_pkg::KeyW-1:0] key_i,
  input  logic                     err_i,
  output kda_pkg::res_t            res_o
);

  logic                        accept_en_q, accept_en_d;
  logic                        repeating_q, repeating_d;
  logic [kda_pkg::KeyW-1:0]    prev_key_q, prev_key_d;
  logic [kda_pkg::PeriodW-1:0] countdown_q, countdown_d;
  logic [kda_pkg::SlowCntW-1:0] slow_left_q, slow_left_d;
  logic [kda_pkg::KeyW-1:0]    last_cmd_q, last_cmd_d;
  logic                        valid, clear;
  logic                        is_horiz, is_vert, is_other;

  assign is_horiz = (key_i == kda_pkg::KeyRight) || (key_i == kda_pkg::KeyLeft);
  assign is_vert  = (key_i == kda_pkg::KeyUp) || (key_i == kda_pkg::KeyDown);
  assign is_other = (key_i == kda_pkg::KeyExec) || (key_i == kda_pkg::KeyOutput) ||
                    (key_i == kda_pkg::KeyPreset) || (key_i == kda_pkg::KeyGenlock);

  always_comb begin
    accept_en_d = accept_en_q;
    repeating_d = repeating_q;
    prev_key_d  = prev_key_q;
    countdown_d = countdown_q;
    slow_left_d = slow_left_q;
    last_cmd_d  = last_cmd_q;
    valid       = 1'b0;
    clear       = 1'b0;
    if (!err_i) begin
      if (accept_en_q) begin
        if (repeating_q) begin
          if (key_i == prev_key_q) begin
            if (countdown_q == '0) begin
              last_cmd_d = key_i;
              valid      = 1'b1;
              if (slow_left_q != '0) begin
                slow_left_d = slow_left_q - 1'b1;
                countdown_d = cfg_i.normal_period;
              end else begin
                countdown_d = cfg_i.fast_period;
              end
            end else begin
              countdown_d = countdown_q - 1'b1;
            end
          end else begin
            // code changed: stop repeating, no command
            repeating_d = 1'b0;
          end
        end else if (key_i != kda_pkg::KeyNone) begin
          if (key_i == prev_key_q) begin
            clear = 1'b1;
            if (is_horiz || is_vert) begin
              if ((is_horiz && cfg_i.horiz_repeat) || (is_vert && cfg_i.vert_repeat)) begin
                repeating_d = 1'b1;
              end else begin
                accept_en_d = 1'b0;
              end
              slow_left_d = kda_pkg::SlowRepeats;
              countdown_d = cfg_i.normal_period;
              last_cmd_d  = key_i;
              valid       = 1'b1;
            end else if (is_other) begin
              accept_en_d = 1'b0;
              last_cmd_d  = key_i;
              valid       = 1'b1;
            end
          end else begin
            prev_key_d = key_i;
          end
        end else begin
          prev_key_d = kda_pkg::KeyNone;
        end
      end else if (key_i == kda_pkg::KeyNone) begin
        // release unlocks
        accept_en_d = 1'b1;
        last_cmd_d  = kda_pkg::KeyNone;
        prev_key_d  = kda_pkg::KeyNone;
        repeating_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_en_q <= 1'b0;
      repeating_q <= 1'b0;
      prev_key_q  <= '0;
      countdown_q <= '0;
      slow_left_q <= '0;
      last_cmd_q  <= '0;
    end else if (step_i) begin
      accept_en_q <= accept_en_d;
      repeating_q <= repeating_d;
      prev_key_q  <= prev_key_d;
      countdown_q <= countdown_d;
      slow_left_q <= slow_left_d;
      last_cmd_q  <= last_cmd_d;
    end
  end

  assign res_o.cmd_valid   = valid;
  assign res_o.cmd_key     = last_cmd_d;
  assign res_o.timer_clear = clear;

endmodule

@@ rtl/keypad_debounce_autorepeat.sv @@
// Keypad debounce with auto-repeat: one scan in per transfer, one command result out per scan.
// Depends on kda_pkg, kda_cfg and kda_core.
//
// Each scan transfer yields exactly one result transfer, after the scan passes through the input
// register and then the result register. A scan can be taken every cycle; the only limit is
// the result register, which holds while the downstream side stalls. The whole debounce and
// repeat update is combinational logic in kda_core. The user must write configuration through
// the cfg port only while no scan is in flight; the block itself does not enforce this.
module keypad_debounce_autorepeat (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kda_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kda_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] key_code
  input  logic                         s_axis_tuser,  // [0] read_error
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] command_key
  output logic [1:0]                   m_axis_tuser   // [0] command_valid, [1] idle_timer_clear
);

  kda_pkg::cfg_t            cfg;
  kda_pkg::res_t            res;
  logic                     in_vld_q;
  logic [kda_pkg::KeyW-1:0] in_key_q;
  logic                     in_err_q;
  logic                     out_vld_q;
  kda_pkg::res_t            out_q;
  logic                     advance;

  // move the input register into the result register when the result slot frees up
  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;

  kda_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  kda_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (in_vld_q && advance),
    .key_i  (in_key_q),
    .err_i  (in_err_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_key_q <= s_axis_tdata;
      in_err_q <= s_axis_tuser;
    end
    if (advance && in_vld_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_q.cmd_key;
  assign m_axis_tuser[0] = out_q.cmd_valid;
  assign m_axis_tuser[1] = out_q.timer_clear;

endmodule

@@ test/kda_checker.sv @@
// Command checker for keypad_debounce_autorepeat: follows register writes, predicts one
// command result per scan transfer and compares result transfers in order. Depends on kda_pkg.
module kda_checker
  import kda_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                scan_valid_i,
  input  logic                scan_ready_i,
  input  logic [KeyW-1:0]     scan_data_i,
  input  logic                scan_user_i,
  input  logic                cmd_valid_i,
  input  logic                cmd_ready_i,
  input  logic [KeyW-1:0]     cmd_data_i,
  input  logic [1:0]          cmd_user_i,
  output int                  errors_o,
  output int                  outstanding_o
);

  cfg_t                regs;
  logic                accept_en;
  logic                repeating;
  logic [KeyW-1:0]     prev_key;
  logic [KeyW-1:0]     last_cmd;
  logic [PeriodW-1:0]  countdown;
  logic [SlowCntW-1:0] slow_left;
  res_t                cmd_q[$];
  int                  fail_cnt;

  // Advance the debounce state by one scan and return the command it yields.
  task automatic debounce_scan(input logic [KeyW-1:0] key, input logic rd_err,
                               output res_t r);
    logic allow;
    r = '0;
    if (!rd_err) begin
      if (accept_en) begin
        if (repeating) begin
          if (key == prev_key) begin
            if (countdown == '0) begin
              last_cmd    = key;
              r.cmd_valid = 1'b1;
              if (slow_left != '0) begin
                slow_left = slow_left - 1'b1;
                countdown = regs.normal_period;
              end else begin
                countdown = regs.fast_period;
              end
            end else begin
              countdown = countdown - 1'b1;
            end
          end else begin
            // code changed mid-repeat: stop quietly, keep the old key
            repeating = 1'b0;
          end
        end else if (key != KeyNone) begin
          if (key == prev_key) begin
            r.timer_clear = 1'b1;
            case (key)
              KeyRight, KeyLeft, KeyUp, KeyDown: begin
                allow = (key == KeyUp || key == KeyDown) ? regs.vert_repeat : regs.horiz_repeat;
                if (allow) begin
                  repeating = 1'b1;
                end else begin
                  accept_en = 1'b0;
                end
                slow_left   = SlowRepeats;
                countdown   = regs.normal_period;
                last_cmd    = key;
                r.cmd_valid = 1'b1;
              end
              KeyExec, KeyOutput, KeyPreset, KeyGenlock: begin
                accept_en   = 1'b0;
                last_cmd    = key;
                r.cmd_valid = 1'b1;
              end
              default: begin
              end
            endcase
          end else begin
            prev_key = key;
          end
        end else begin
          prev_key = KeyNone;
        end
      end else if (key == KeyNone) begin
        // release unlocks
        accept_en = 1'b1;
        last_cmd  = KeyNone;
        prev_key  = KeyNone;
        repeating = 1'b0;
      end
    end
    r.cmd_key = last_cmd;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      regs.horiz_repeat  = 1'b0;
      regs.vert_repeat   = 1'b0;
      regs.normal_period = NormalPeriodRst;
      regs.fast_period   = FastPeriodRst;
      accept_en          = 1'b0;
      repeating          = 1'b0;
      prev_key           = KeyNone;
      last_cmd           = KeyNone;
      countdown          = '0;
      slow_left          = '0;
      cmd_q.delete();
      fail_cnt           = 0;
      errors_o          <= 0;
      outstanding_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgHorizRepeat: regs.horiz_repeat  = cfg_data_i[0];
          CfgVertRepeat:  regs.vert_repeat   = cfg_data_i[0];
          CfgNormalPer:   regs.normal_period = cfg_data_i[PeriodW-1:0];
          CfgFastPer:     regs.fast_period   = cfg_data_i[PeriodW-1:0];
          default: begin
          end
        endcase
      end
      if (scan_valid_i && scan_ready_i) begin
        debounce_scan(scan_data_i, scan_user_i, want);
        cmd_q.push_back(want);
      end
      if (cmd_valid_i && cmd_ready_i) begin
        got.cmd_valid   = cmd_user_i[0];
        got.cmd_key     = cmd_data_i;
        got.timer_clear = cmd_user_i[1];
        if (cmd_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected command transfer: valid=%0b key=%0d clear=%0b",
                   $time, got.cmd_valid, got.cmd_key, got.timer_clear);
        end else begin
          want = cmd_q.pop_front();
          if (got !== want) begin
            fail_cnt++;
            $display("%0t: mismatch: exp v=%0b k=%0d c=%0b, act v=%0b k=%0d c=%0b",
                     $time, want.cmd_valid, want.cmd_key, want.timer_clear,
                     got.cmd_valid, got.cmd_key, got.timer_clear);
          end
        end
      end
      errors_o      <= fail_cnt;
      outstanding_o <= cmd_q.size();
    end
  end

endmodule

@@ test/tb_keypad_debounce_autorepeat.sv @@
// Stimulus and verdict for keypad_debounce_autorepeat: directed scans, then random key
// episodes under several register settings and stall patterns. Depends on kda_pkg, kda_checker.
module tb_keypad_debounce_autorepeat;
  import kda_pkg::*;

  localparam int ScanTarget = 1750;
  localparam int CycleLimit = 200000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [7:0]          m_tdata;
  logic [1:0]          m_tuser;

  int src_idle_pct;
  int snk_stall_pct;
  int scans_sent = 0;
  int cycles = 0;
  int errors;
  int outstanding;

  always #4 clk = ~clk;

  keypad_debounce_autorepeat dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  kda_checker u_cmd_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .scan_valid_i  (s_tvalid),
    .scan_ready_i  (s_tready),
    .scan_data_i   (s_tdata),
    .scan_user_i   (s_tuser),
    .cmd_valid_i   (m_tvalid),
    .cmd_ready_i   (m_tready),
    .cmd_data_i    (m_tdata),
    .cmd_user_i    (m_tuser),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  always @(posedge clk) m_tready <= ($urandom_range(99) >= snk_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_scan(input logic [KeyW-1:0] key, input logic rd_err);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tuser  <= rd_err;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    scans_sent++;
  endtask

  // Hold one code for n scans, with failed reads sprinkled in.
  task automatic hold_key(input logic [KeyW-1:0] key, input int n);
    repeat (n) begin
      if ($urandom_range(99) < 6) send_scan(KeyW'($urandom), 1'b1);
      send_scan(key, 1'b0);
    end
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 55) return KeyW'(KeyRight + $urandom_range(3));
    if (r < 75) return KeyW'(KeyExec + $urandom_range(3));
    return KeyW'($urandom_range(9, 255));
  endfunction

  // One press: hold, maybe slide to another code or glitch, then mostly release.
  task automatic key_episode();
    int roll;
    int len;
    roll = $urandom_range(99);
    if (roll < 1) len = $urandom_range(260, 300);
    else if (roll < 11) len = $urandom_range(16, 40);
    else len = $urandom_range(1, 15);
    hold_key(pick_key(), len);
    roll = $urandom_range(99);
    if (roll < 15) hold_key(pick_key(), $urandom_range(1, 6));
    else if (roll < 25) send_scan(KeyW'($urandom), 1'b0);
    if ($urandom_range(9) != 0) hold_key(KeyNone, $urandom_range(1, 3));
  endtask

  // Drop valid and let every result drain before touching registers.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Hold the write for one edge; the caller drops the enable after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_keypad(input logic horiz, input logic vert,
                                input logic [PeriodW-1:0] normal,
                                input logic [PeriodW-1:0] fast);
    drain();
    write_reg(CfgHorizRepeat, CfgDataW'(horiz));
    write_reg(CfgVertRepeat, CfgDataW'(vert));
    write_reg(CfgNormalPer, CfgDataW'(normal));
    write_reg(CfgFastPer, CfgDataW'(fast));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int base;
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CfgHorizRepeat;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    src_idle_pct  = 9;
    snk_stall_pct = 52;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, no repeat: locked start, failed read, named keys, combination.
    send_scan(KeyExec, 1'b0);
    send_scan(KeyNone, 1'b0);
    send_scan(8'hFF, 1'b1);
    send_scan(KeyExec, 1'b0);
    send_scan(KeyExec, 1'b0);
    send_scan(KeyOutput, 1'b0);
    send_scan(KeyNone, 1'b0);
    send_scan(8'h81, 1'b0);
    send_scan(8'h81, 1'b0);
    send_scan(KeyRight, 1'b0);
    send_scan(KeyRight, 1'b0);
    send_scan(KeyNone, 1'b0);
    send_scan(KeyGenlock, 1'b0);
    send_scan(KeyGenlock, 1'b0);
    send_scan(KeyNone, 1'b0);

    // Zero periods: repeat on every scan, then a code change during repeat.
    program_keypad(1'b1, 1'b1, 8'd0, 8'd0);
    repeat (8) send_scan(KeyLeft, 1'b0);
    repeat (3) send_scan(KeyDown, 1'b0);
    send_scan(KeyNone, 1'b0);

    base = scans_sent;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        src_idle_pct  = 52;
        snk_stall_pct = 9;
      end
      if (ph == 4) begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      case (ph)
        0: program_keypad(1'b1, 1'b1, 8'd3, 8'd1);
        1: begin
          program_keypad(1'b1, 1'b0, 8'd255, 8'd0);
          hold_key(KeyNone, 1);
          hold_key(KeyRight, 270);
          hold_key(KeyNone, 1);
        end
        2: begin
          program_keypad(1'b0, 1'b1, 8'd0, 8'd255);
          hold_key(KeyNone, 1);
          hold_key(KeyDown, 270);
          hold_key(KeyNone, 1);
        end
        4: program_keypad(1'b1, 1'b1, 8'd1, 8'd0);
        default: program_keypad(1'($urandom_range(1)), 1'($urandom_range(1)),
                                PeriodW'($urandom_range(0, 6)), PeriodW'($urandom_range(0, 3)));
      endcase
      while (scans_sent < base + (ph + 1) * ScanTarget / 6) key_episode();
    end

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
